// File: sv/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg: shared types and constants for the card number classifier
// Digit widths, counter widths, issuer codes and the sequencer states.
// ----------------------------------------------------------------------------
package clc_pkg;

	localparam int VALUE_W    = 63;
	localparam int DIGITS     = 19;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int BIT_CNT_W  = 6;
	localparam int DIG_CNT_W  = 5;

	localparam logic [1:0] KIND_INVALID = 2'd0;
	localparam logic [1:0] KIND_PFX_34  = 2'd1;
	localparam logic [1:0] KIND_PFX_5X  = 2'd2;
	localparam logic [1:0] KIND_LEAD_4  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// File: sv/card_number_luhn_classifier.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: Luhn check and issuer class of a card number
// Converts the binary number to BCD one bit per cycle, then walks the digits
// one per cycle to form the mod-10 sum, the length and the leading pair.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | card_value
//  out     | out_valid / out_stall| issuer_kind, checksum_ok, digit_count
//
//  Steps per request: accept, 63 shift-add-3 steps (one per input bit),
//  19 digit steps (one per BCD digit), then a load of the output register.
//  One request is in flight at a time; in_stall is high while it is worked on.
//  A finished result waits in the output register; the block holds in the
//  final step only if that register is still full and out_stall is high.
//  arst_n clears the sequencer and out_valid.
module card_number_luhn_classifier #(
	parameter int MAX_DIGITS = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [62:0] card_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  issuer_kind,
	output logic        checksum_ok,
	output logic [4:0]  digit_count
);

	clc_pkg::state_t state_q, state_d;

	logic [clc_pkg::VALUE_W-1:0]   bin_q;
	logic [clc_pkg::BCD_W-1:0]     bcd_q;
	logic [clc_pkg::BCD_W-1:0]     bcd_adj;
	logic [clc_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic [clc_pkg::DIG_CNT_W-1:0] dig_cnt_q;
	logic [3:0]                    sum_q;
	logic [4:0]                    count_q;
	logic [3:0]                    hi_q, lo_q, prev_q;

	logic                          out_valid_q;
	logic [1:0]                    kind_q;
	logic                          ok_q;
	logic [4:0]                    count_out_q;

	logic                          do_load, do_convert, do_scan, do_emit;
	logic                          last_bit, last_digit, out_free;

	logic [3:0]                    dig;
	logic [3:0]                    dig_add;
	logic [4:0]                    sum_wide;
	logic [3:0]                    sum_next;
	logic                          ok_c;
	logic [1:0]                    kind_c;

	assign last_bit   = (bit_cnt_q == clc_pkg::BIT_CNT_W'(clc_pkg::VALUE_W - 1));
	assign last_digit = (dig_cnt_q == clc_pkg::DIG_CNT_W'(clc_pkg::DIGITS - 1));
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clc_pkg::ST_IDLE: begin
				if (in_valid) state_d = clc_pkg::ST_CONVERT;
			end
			clc_pkg::ST_CONVERT: begin
				if (last_bit) state_d = clc_pkg::ST_SCAN;
			end
			clc_pkg::ST_SCAN: begin
				if (last_digit) state_d = clc_pkg::ST_FINISH;
			end
			clc_pkg::ST_FINISH: begin
				if (out_free) state_d = clc_pkg::ST_IDLE;
			end
			default: state_d = clc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		do_load    = 1'b0;
		do_convert = 1'b0;
		do_scan    = 1'b0;
		do_emit    = 1'b0;
		unique case (state_q)
			clc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				do_load  = in_valid;
			end
			clc_pkg::ST_CONVERT: do_convert = 1'b1;
			clc_pkg::ST_SCAN:    do_scan    = 1'b1;
			clc_pkg::ST_FINISH:  do_emit    = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// shift-add-3: correct every BCD digit, then shift in the next binary bit
	always_comb begin
		for (int i = 0; i < clc_pkg::DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                            : bcd_q[4*i +: 4];
		end
	end

	// digit walk, least significant first; every second digit, starting with the second, is doubled
	assign dig = bcd_q[3:0];

	always_comb begin
		if (!dig_cnt_q[0]) begin
			dig_add = dig;
		end else if (dig < 4'd5) begin
			dig_add = {dig[2:0], 1'b0};
		end else begin
			dig_add = 4'(({1'b0, dig} << 1) - 5'd9);
		end
		sum_wide = {1'b0, sum_q} + {1'b0, dig_add};
		sum_next = (sum_wide >= 5'd10) ? 4'(sum_wide - 5'd10) : sum_wide[3:0];
	end

	always_comb begin
		ok_c   = (sum_q == 4'd0) && (count_q <= 5'(MAX_DIGITS));
		kind_c = clc_pkg::KIND_INVALID;
		if (ok_c) begin
			priority if (count_q == 5'd15 && hi_q == 4'd3 && (lo_q == 4'd4 || lo_q == 4'd7))
				kind_c = clc_pkg::KIND_PFX_34;
			else if (count_q == 5'd16 && hi_q == 4'd5 && lo_q >= 4'd1 && lo_q <= 4'd5)
				kind_c = clc_pkg::KIND_PFX_5X;
			else if ((count_q == 5'd13 || count_q == 5'd16) && hi_q == 4'd4)
				kind_c = clc_pkg::KIND_LEAD_4;
			else
				kind_c = clc_pkg::KIND_INVALID;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			bin_q     <= card_value;
			bcd_q     <= '0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			prev_q    <= '0;
		end else if (do_convert) begin
			bcd_q     <= {bcd_adj[clc_pkg::BCD_W-2:0], bin_q[clc_pkg::VALUE_W-1]};
			bin_q     <= {bin_q[clc_pkg::VALUE_W-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end else if (do_scan) begin
			bcd_q     <= {4'd0, bcd_q[clc_pkg::BCD_W-1:4]};
			dig_cnt_q <= dig_cnt_q + 1'b1;
			sum_q     <= sum_next;
			prev_q    <= dig;
			if (dig != 4'd0) begin
				count_q <= 5'(dig_cnt_q) + 5'd1;
				hi_q    <= dig;
				lo_q    <= prev_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			kind_q      <= kind_c;
			ok_q        <= ok_c;
			count_out_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign issuer_kind = kind_q;
	assign checksum_ok = ok_q;
	assign digit_count = count_out_q;

endmodule
